[hw/rtl/tsd_pkg.sv]
package tsd_pkg;

   // Defaults for the top-level parameters
   localparam int CAL_COUNT_DEF   = 100;
   localparam int SAMPLE_BITS_DEF = 10;

   // Fixed field widths
   localparam int SAMPLE_W  = 10;
   localparam int THRESH_W  = 11;
   localparam int MAG_W     = 11;
   localparam int STEP_W    = 16;
   localparam int CAL_CNT_W = 7;

   localparam logic [THRESH_W-1:0] THRESH_RESET = 11'd30;
   localparam logic [MAG_W-1:0]    MAG_MAX      = '1;
   localparam logic [STEP_W-1:0]   STEP_MAX     = '1;

   // Sample opcodes
   localparam logic OP_CAL    = 1'b0;
   localparam logic OP_DETECT = 1'b1;

   // Step detector phase
   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_ARMED = 2'd1,
      PH_DEAD  = 2'd2
   } phase_type;

   // Item sequencer
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQSUM,
      ST_ROOT,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                op;
      logic [SAMPLE_W-1:0] sample_x;
      logic [SAMPLE_W-1:0] sample_y;
      logic [SAMPLE_W-1:0] sample_z;
   } req_type;

   typedef struct packed {
      logic [MAG_W-1:0]  magnitude;
      logic [STEP_W-1:0] step_count;
      logic [1:0]        detect_phase;
      logic              step_taken;
      logic              calibrated;
   } rsp_type;

endpackage

[hw/rtl/tsd_sqsum.sv]
module tsd_sqsum #(
   parameter int CAL_COUNT   = tsd_pkg::CAL_COUNT_DEF,
   parameter int SAMPLE_BITS = tsd_pkg::SAMPLE_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [SAMPLE_BITS-1:0]       samp_x,
   input  logic [SAMPLE_BITS-1:0]       samp_y,
   input  logic [SAMPLE_BITS-1:0]       samp_z,
   input  logic [SAMPLE_BITS+6:0]       rest_x,
   input  logic [SAMPLE_BITS+6:0]       rest_y,
   input  logic [SAMPLE_BITS+6:0]       rest_z,
   output logic                         done,
   output logic [2*SAMPLE_BITS+15:0]    sum
);

   localparam int AW = SAMPLE_BITS + 7;
   localparam int SW = 2 * AW + 2;
   localparam logic [2:0] CNT_LAST  = 3'd4;
   localparam logic [2:0] CNT_ACCUM = 3'd2;

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [2:0]             cnt_ff, cnt_in;
   logic [SAMPLE_BITS-1:0] axis;
   logic [AW-1:0]          rest_sel;
   logic [AW-1:0]          prod;
   logic [AW:0]            diff;
   logic [AW-1:0]          abs_dev;
   logic [AW-1:0]          ad_ff;
   logic [2*AW-1:0]        sq_ff;
   logic [SW-1:0]          sum_ff, sum_in;

   // Pick one axis per cycle and form |N*axis - rest|
   always_comb begin
      unique case (cnt_ff)
         3'd0: begin
            axis     = samp_x;
            rest_sel = rest_x;
         end
         3'd1: begin
            axis     = samp_y;
            rest_sel = rest_y;
         end
         default: begin
            axis     = samp_z;
            rest_sel = rest_z;
         end
      endcase
      prod    = AW'(axis) * AW'(CAL_COUNT);
      diff    = {1'b0, prod} - {1'b0, rest_sel};
      abs_dev = diff[AW] ? AW'(-diff) : diff[AW-1:0];
   end

   // Advance the three-stage deviation, square, accumulate pipe
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      sum_in  = sum_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         sum_in  = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 3'd1;
         if (cnt_ff >= CNT_ACCUM) begin
            sum_in = sum_ff + SW'(sq_ff);
         end
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      ad_ff  <= abs_dev;
      sq_ff  <= (2*AW)'(ad_ff) * (2*AW)'(ad_ff);
      sum_ff <= sum_in;
   end

   assign done = done_ff;
   assign sum  = sum_ff;

endmodule

[hw/rtl/tsd_isqrt.sv]
module tsd_isqrt #(
   parameter int SAMPLE_BITS = tsd_pkg::SAMPLE_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [2*SAMPLE_BITS+15:0] radicand,
   output logic                      done,
   output logic [SAMPLE_BITS+7:0]    root
);

   localparam int SW  = 2 * SAMPLE_BITS + 16;
   localparam int QW  = SAMPLE_BITS + 8;
   localparam int RMW = QW + 3;
   localparam int CW  = $clog2(QW + 1);
   localparam logic [CW-1:0] CNT_LAST = CW'(QW - 1);

   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [SW-1:0]  rad_ff, rad_in;
   logic [RMW-1:0] rem_ff, rem_in;
   logic [QW-1:0]  root_ff, root_in;
   logic [RMW-1:0] rem_sh;
   logic [RMW-1:0] trial;
   logic           fits;

   // Bring in two radicand bits, try 4*root+1, retire one root bit
   always_comb begin
      rem_sh = {rem_ff[RMW-3:0], rad_ff[SW-1:SW-2]};
      trial  = RMW'({root_ff, 2'b01});
      fits   = (rem_sh >= trial);

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rad_in = {rad_ff[SW-3:0], 2'b00};
         if (fits) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[QW-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[QW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

[hw/rtl/tsd_cdiv.sv]
module tsd_cdiv #(
   parameter int DIVISOR = tsd_pkg::CAL_COUNT_DEF,
   parameter int WIDTH   = tsd_pkg::SAMPLE_BITS_DEF + 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   output logic             done,
   output logic [WIDTH-1:0] quotient
);

   localparam int DRW = $clog2(DIVISOR + 1) + 1;
   localparam int CW  = $clog2(WIDTH + 1);
   localparam logic [CW-1:0]  CNT_LAST = CW'(WIDTH - 1);
   localparam logic [DRW-1:0] DIV_VAL  = DRW'(DIVISOR);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [DRW-2:0]   rem_ff, rem_in;
   logic [DRW-1:0]   rem_sh;
   logic [DRW-1:0]   rem_dif;
   logic             fits;

   // Shift one dividend bit into the remainder, subtract when it fits
   always_comb begin
      rem_sh  = {rem_ff, quo_ff[WIDTH-1]};
      fits    = (rem_sh >= DIV_VAL);
      rem_dif = rem_sh - DIV_VAL;

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         quo_in = {quo_ff[WIDTH-2:0], fits};
         rem_in = fits ? rem_dif[DRW-2:0] : rem_sh[DRW-2:0];
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[hw/rtl/threshold_step_detector.sv]
// Three-axis accelerometer step counter. A calibration sample (op 0) adds into per-axis
// sums and, after CAL_COUNT of them, latches those sums as the rest point; its result goes
// through the done state into the result register. A detection sample (op 1) reports the
// floor of its distance from the rest point and steps the idle/armed/dead detector, counting
// a step on the sample after one whose magnitude reaches step_threshold. The squared
// deviations of the three axes pass in turn through one squaring multiplier, then the square
// root and the divide by CAL_COUNT each retire one bit per cycle. One sample is in work at a
// time; the result register lets the next sample enter while a result still waits. The
// threshold register is to be written only while no sample is in work; the block itself
// does not enforce this.
module threshold_step_detector #(
   parameter int CAL_COUNT   = tsd_pkg::CAL_COUNT_DEF,
   parameter int SAMPLE_BITS = tsd_pkg::SAMPLE_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  tsd_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output tsd_pkg::rsp_type               rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [tsd_pkg::THRESH_W-1:0]   csr_data
);

   import tsd_pkg::*;

   localparam int AW  = SAMPLE_BITS + 7;
   localparam int SW  = 2 * AW + 2;
   localparam int QW  = SAMPLE_BITS + 8;
   localparam int SXW = (SAMPLE_BITS > SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;

   state_type              state_ff, state_in;
   logic [THRESH_W-1:0]    thresh_ff;
   logic                   op_ff;
   logic [SAMPLE_BITS-1:0] samp_x_ff, samp_y_ff, samp_z_ff;
   logic [AW-1:0]          acc_x_ff, acc_y_ff, acc_z_ff;
   logic [AW-1:0]          acc_x_in, acc_y_in, acc_z_in;
   logic [AW-1:0]          rest_x_ff, rest_y_ff, rest_z_ff;
   logic [AW-1:0]          rest_x_in, rest_y_in, rest_z_in;
   logic [CAL_CNT_W-1:0]   cal_cnt_ff, cal_cnt_in;
   logic                   cal_valid_ff, cal_valid_in;
   phase_type              phase_ff, phase_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   logic [SXW-1:0]         wide_x, wide_y, wide_z;
   logic [SAMPLE_BITS-1:0] in_x, in_y, in_z;
   logic                   accept;
   logic                   sq_start, root_start, div_start, load_out;
   logic                   sq_done, root_done, div_done;
   logic [SW-1:0]          sq_sum;
   logic [QW-1:0]          root;
   logic [QW-1:0]          quotient;
   logic [MAG_W-1:0]       mag_sat;
   logic [CAL_CNT_W:0]     cal_next;
   logic [AW-1:0]          sum_x, sum_y, sum_z;
   phase_type              det_phase;
   logic [STEP_W-1:0]      det_step;
   logic                   det_taken;

   // Reduce each reading modulo 2^SAMPLE_BITS
   assign wide_x = SXW'(req_data.sample_x);
   assign wide_y = SXW'(req_data.sample_y);
   assign wide_z = SXW'(req_data.sample_z);
   assign in_x   = wide_x[SAMPLE_BITS-1:0];
   assign in_y   = wide_y[SAMPLE_BITS-1:0];
   assign in_z   = wide_z[SAMPLE_BITS-1:0];

   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // Sequence one sample through the arithmetic units
   always_comb begin
      state_in   = state_ff;
      req_stall  = 1'b1;
      sq_start   = 1'b0;
      root_start = 1'b0;
      div_start  = 1'b0;
      load_out   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_data.op == OP_DETECT) begin
                  sq_start = 1'b1;
                  state_in = ST_SQSUM;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SQSUM: begin
            if (sq_done) begin
               root_start = 1'b1;
               state_in   = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (root_done) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Accumulate calibration samples; latch the rest sums on a full set
   always_comb begin
      cal_next     = {1'b0, cal_cnt_ff} + (CAL_CNT_W+1)'(1);
      sum_x        = acc_x_ff + AW'(in_x);
      sum_y        = acc_y_ff + AW'(in_y);
      sum_z        = acc_z_ff + AW'(in_z);
      acc_x_in     = acc_x_ff;
      acc_y_in     = acc_y_ff;
      acc_z_in     = acc_z_ff;
      rest_x_in    = rest_x_ff;
      rest_y_in    = rest_y_ff;
      rest_z_in    = rest_z_ff;
      cal_cnt_in   = cal_cnt_ff;
      cal_valid_in = cal_valid_ff;
      if (accept && req_data.op == OP_CAL) begin
         if (cal_next >= (CAL_CNT_W+1)'(CAL_COUNT)) begin
            rest_x_in    = sum_x;
            rest_y_in    = sum_y;
            rest_z_in    = sum_z;
            acc_x_in     = '0;
            acc_y_in     = '0;
            acc_z_in     = '0;
            cal_cnt_in   = '0;
            cal_valid_in = 1'b1;
         end else begin
            acc_x_in   = sum_x;
            acc_y_in   = sum_y;
            acc_z_in   = sum_z;
            cal_cnt_in = cal_next[CAL_CNT_W-1:0];
         end
      end
   end

   // Saturate the magnitude and step the detector
   always_comb begin
      mag_sat   = (quotient > QW'(MAG_MAX)) ? MAG_MAX : quotient[MAG_W-1:0];
      det_phase = phase_ff;
      det_step  = step_ff;
      det_taken = 1'b0;
      if (op_ff == OP_DETECT) begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (mag_sat >= thresh_ff) begin
                  det_phase = PH_ARMED;
               end
            end
            PH_ARMED: begin
               if (step_ff != STEP_MAX) begin
                  det_step  = step_ff + STEP_W'(1);
                  det_taken = 1'b1;
               end
               det_phase = PH_DEAD;
            end
            default: begin
               det_phase = PH_IDLE;
            end
         endcase
      end
   end

   // Load the result register; drop it once transferred
   always_comb begin
      phase_in     = phase_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (load_out) begin
         phase_in                 = det_phase;
         step_in                  = det_step;
         rsp_valid_in             = 1'b1;
         rsp_data_in.magnitude    = (op_ff == OP_DETECT) ? mag_sat : '0;
         rsp_data_in.step_count   = det_step;
         rsp_data_in.detect_phase = det_phase;
         rsp_data_in.step_taken   = det_taken;
         rsp_data_in.calibrated   = cal_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         thresh_ff    <= THRESH_RESET;
         acc_x_ff     <= '0;
         acc_y_ff     <= '0;
         acc_z_ff     <= '0;
         rest_x_ff    <= '0;
         rest_y_ff    <= '0;
         rest_z_ff    <= '0;
         cal_cnt_ff   <= '0;
         cal_valid_ff <= 1'b0;
         phase_ff     <= PH_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_valid && csr_ready) begin
            thresh_ff <= csr_data;
         end
         acc_x_ff     <= acc_x_in;
         acc_y_ff     <= acc_y_in;
         acc_z_ff     <= acc_z_in;
         rest_x_ff    <= rest_x_in;
         rest_y_ff    <= rest_y_in;
         rest_z_ff    <= rest_z_in;
         cal_cnt_ff   <= cal_cnt_in;
         cal_valid_ff <= cal_valid_in;
         phase_ff     <= phase_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the accepted sample for the arithmetic units
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_data.op;
         samp_x_ff <= in_x;
         samp_y_ff <= in_y;
         samp_z_ff <= in_z;
      end
      rsp_data_ff <= rsp_data_in;
   end

   tsd_sqsum #(
      .CAL_COUNT   (CAL_COUNT),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_sqsum (
      .clock  (clock),
      .reset  (reset),
      .start  (sq_start),
      .samp_x (samp_x_ff),
      .samp_y (samp_y_ff),
      .samp_z (samp_z_ff),
      .rest_x (rest_x_ff),
      .rest_y (rest_y_ff),
      .rest_z (rest_z_ff),
      .done   (sq_done),
      .sum    (sq_sum)
   );

   tsd_isqrt #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (sq_sum),
      .done     (root_done),
      .root     (root)
   );

   tsd_cdiv #(
      .DIVISOR (CAL_COUNT),
      .WIDTH   (QW)
   ) u_cdiv (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (root),
      .done     (div_done),
      .quotient (quotient)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[hw/rtl/tsd_checker.sv]
module tsd_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input tsd_pkg::rsp_type rsp_data
);

   import tsd_pkg::*;

   // A stalled result stays offered and unchanged
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // One sample in work at a time: a transfer in closes the input
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input open in the cycle after a transfer");

   // A counted step always leaves the detector dead
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.step_taken |-> rsp_data.detect_phase == PH_DEAD)
      else $error("step taken outside the dead phase");

   // A counted step shows a nonzero count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.step_taken |-> rsp_data.step_count != '0)
      else $error("step taken with zero step count");

endmodule

bind threshold_step_detector tsd_checker u_tsd_checker (.*);

[bench/tb_threshold_step_detector.sv]
`timescale 1ns / 100ps

module tb_threshold_step_detector;
   import tsd_pkg::*;

   localparam int CAL_N       = CAL_COUNT_DEF;
   localparam int ACC_W       = SAMPLE_W + 7;
   localparam int SAMPLE_TOP  = (1 << SAMPLE_W) - 1;
   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_WAIT  = 60;

   logic                clock;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   req_type             req_data  = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   rsp_type             rsp_data;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [THRESH_W-1:0] csr_data  = '0;

   threshold_step_detector dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // Samples waiting to be driven, and reports predicted for accepted samples
   req_type sample_q[$];
   rsp_type pending_reports[$];

   // Pedometer state as the block should hold it
   logic [ACC_W-1:0]     cal_sum_x, cal_sum_y, cal_sum_z;
   logic [ACC_W-1:0]     rest_x, rest_y, rest_z;
   logic [CAL_CNT_W-1:0] cal_seen;
   logic                 is_calibrated;
   phase_type            det_phase;
   logic [STEP_W-1:0]    step_total;
   logic [THRESH_W-1:0]  step_threshold;

   // Stimulus-side view of the calibration fill and the current rest point
   int cal_fill;
   int cx, cy, cz;

   int req_gap, req_quiet, rsp_hold, rsp_quiet;
   int error_count, cycle_count;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Draw an idle length; now and then run a stretch with no idling at all
   function automatic int draw_gap(inout int quiet);
      if (quiet > 0) begin
         quiet--;
         return 0;
      end
      if ($urandom_range(0, 24) == 0) begin
         quiet = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 6);
   endfunction

   function automatic longint square_dev(input logic [SAMPLE_W-1:0] s,
                                         input logic [ACC_W-1:0] rest);
      longint d;
      d = longint'(s) * CAL_N - longint'(rest);
      return d * d;
   endfunction

   // Advance the pedometer by one accepted sample and queue the report it gives
   function automatic void advance_pedometer(input req_type s);
      rsp_type r;
      longint  total;
      longint  root;
      longint  trial;
      longint  mag;
      r = '0;
      if (s.op == OP_CAL) begin
         cal_sum_x = cal_sum_x + s.sample_x;
         cal_sum_y = cal_sum_y + s.sample_y;
         cal_sum_z = cal_sum_z + s.sample_z;
         cal_seen++;
         // latch a full set as the rest point and start a fresh one
         if (cal_seen >= CAL_N) begin
            rest_x        = cal_sum_x;
            rest_y        = cal_sum_y;
            rest_z        = cal_sum_z;
            cal_sum_x     = '0;
            cal_sum_y     = '0;
            cal_sum_z     = '0;
            cal_seen      = '0;
            is_calibrated = 1'b1;
         end
      end else begin
         total = square_dev(s.sample_x, rest_x) + square_dev(s.sample_y, rest_y)
               + square_dev(s.sample_z, rest_z);
         // floor square root, one bit at a time from the top
         root = 0;
         for (int b = 22; b >= 0; b--) begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= total)
               root = trial;
         end
         mag = root / CAL_N;
         if (mag > MAG_MAX)
            mag = MAG_MAX;
         r.magnitude = mag[MAG_W-1:0];
         case (det_phase)
            PH_IDLE: begin
               if (mag >= step_threshold)
                  det_phase = PH_ARMED;
            end
            PH_ARMED: begin
               if (step_total != STEP_MAX) begin
                  step_total++;
                  r.step_taken = 1'b1;
               end
               det_phase = PH_DEAD;
            end
            default: begin
               det_phase = PH_IDLE;
            end
         endcase
      end
      r.step_count   = step_total;
      r.detect_phase = det_phase;
      r.calibrated   = is_calibrated;
      pending_reports.push_back(r);
   endfunction

   // Driver: present queued samples, idle a drawn number of cycles after each transfer
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            advance_pedometer(req_data);
            req_gap = draw_gap(req_quiet);
         end
         if (!req_valid || !req_stall) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (sample_q.size() > 0) begin
               req_data  <= sample_q.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic report_mismatch(input string field, input logic [15:0] want,
                                  input logic [15:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endtask

   // Monitor: check each result transfer against the oldest prediction
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_reports.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result, expected none, actual %h", $time, rsp_data);
            end else begin
               want = pending_reports.pop_front();
               report_mismatch("magnitude", want.magnitude, rsp_data.magnitude);
               report_mismatch("step_count", want.step_count, rsp_data.step_count);
               report_mismatch("detect_phase", want.detect_phase, rsp_data.detect_phase);
               report_mismatch("step_taken", want.step_taken, rsp_data.step_taken);
               report_mismatch("calibrated", want.calibrated, rsp_data.calibrated);
            end
            rsp_hold = draw_gap(rsp_quiet);
         end else if (rsp_hold > 0) begin
            rsp_hold--;
         end
         rsp_stall <= (rsp_hold > 0);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_threshold_step_detector: FAIL");
         $finish;
      end
   end

   task automatic queue_sample(input logic op, input int x, input int y, input int z);
      req_type s;
      s.op       = op;
      s.sample_x = x[SAMPLE_W-1:0];
      s.sample_y = y[SAMPLE_W-1:0];
      s.sample_z = z[SAMPLE_W-1:0];
      sample_q.push_back(s);
      if (op == OP_CAL)
         cal_fill = (cal_fill + 1) % CAL_N;
   endtask

   function automatic int near(input int c, input int spread);
      int v;
      v = c + $urandom_range(0, 2 * spread) - spread;
      if (v < 0)
         v = 0;
      if (v > SAMPLE_TOP)
         v = SAMPLE_TOP;
      return v;
   endfunction

   function automatic int pick_center();
      if ($urandom_range(0, 3) == 0)
         return $urandom_range(0, 1) ? SAMPLE_TOP : 0;
      return $urandom_range(0, SAMPLE_TOP);
   endfunction

   // Mostly complete calibration sets and walks around the rest point, some noise
   task automatic random_phase(input int n);
      int left;
      int kind;
      int len;
      int spread;
      left = n;
      while (left > 0) begin
         kind = $urandom_range(0, 9);
         if (kind < 2) begin
            // finish the current set around a fresh rest point
            cx     = pick_center();
            cy     = pick_center();
            cz     = pick_center();
            spread = $urandom_range(0, 8);
            len    = CAL_N - cal_fill;
            repeat (len)
               queue_sample(OP_CAL, near(cx, spread), near(cy, spread), near(cz, spread));
         end else if (kind == 2) begin
            // break off a set partway
            len = $urandom_range(1, 20);
            repeat (len)
               queue_sample(OP_CAL, $urandom_range(0, SAMPLE_TOP),
                            $urandom_range(0, SAMPLE_TOP), $urandom_range(0, SAMPLE_TOP));
         end else if (kind < 9) begin
            // walk near the rest point with occasional spikes
            len = $urandom_range(5, 30);
            case ($urandom_range(0, 2))
               0:       spread = 2;
               1:       spread = 25;
               default: spread = 150;
            endcase
            repeat (len) begin
               if ($urandom_range(0, 7) == 0)
                  queue_sample(OP_DETECT, $urandom_range(0, SAMPLE_TOP),
                               $urandom_range(0, SAMPLE_TOP), $urandom_range(0, SAMPLE_TOP));
               else
                  queue_sample(OP_DETECT, near(cx, spread), near(cy, spread),
                               near(cz, spread));
            end
         end else begin
            len = $urandom_range(1, 10);
            repeat (len)
               queue_sample($urandom_range(0, 1) ? OP_DETECT : OP_CAL,
                            $urandom_range(0, SAMPLE_TOP), $urandom_range(0, SAMPLE_TOP),
                            $urandom_range(0, SAMPLE_TOP));
         end
         left -= len;
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (sample_q.size() != 0 || req_valid || pending_reports.size() != 0);
   endtask

   task automatic write_threshold(input logic [THRESH_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid      <= 1'b0;
      step_threshold  = value;
   endtask

   initial begin
      cal_sum_x      = '0;
      cal_sum_y      = '0;
      cal_sum_z      = '0;
      rest_x         = '0;
      rest_y         = '0;
      rest_z         = '0;
      cal_seen       = '0;
      is_calibrated  = 1'b0;
      det_phase      = PH_IDLE;
      step_total     = '0;
      step_threshold = THRESH_RESET;
      cal_fill       = 0;
      cx             = 0;
      cy             = 0;
      cz             = 0;
      req_gap        = 0;
      req_quiet      = 0;
      rsp_hold       = 0;
      rsp_quiet      = 0;
      error_count    = 0;
      cycle_count    = 0;

      // Uncalibrated detection measures from the origin; reset threshold applies
      queue_sample(OP_DETECT, 0, 0, 0);
      queue_sample(OP_DETECT, SAMPLE_TOP, SAMPLE_TOP, SAMPLE_TOP);
      // calibration while armed leaves the detector alone
      queue_sample(OP_CAL, SAMPLE_TOP, 0, SAMPLE_TOP);
      // armed counts a step even on a quiet sample
      queue_sample(OP_DETECT, 0, 0, 0);
      queue_sample(OP_DETECT, SAMPLE_TOP, SAMPLE_TOP, SAMPLE_TOP);
      // just below, then exactly at the threshold
      queue_sample(OP_DETECT, 17, 17, 17);
      queue_sample(OP_DETECT, 30, 0, 0);
      queue_sample(OP_DETECT, SAMPLE_TOP, 0, 0);
      queue_sample(OP_DETECT, 0, SAMPLE_TOP, 0);
      queue_sample(OP_DETECT, 29, 0, 0);
      queue_sample(OP_DETECT, 0, 0, SAMPLE_TOP);
      queue_sample(OP_CAL, 0, 0, 0);
      queue_sample(OP_CAL, SAMPLE_TOP, SAMPLE_TOP, SAMPLE_TOP);
      queue_sample(OP_CAL, 682, 341, 682);
      queue_sample(OP_DETECT, 341, 682, 0);
      queue_sample(OP_DETECT, 682, 341, SAMPLE_TOP);
      queue_sample(OP_DETECT, 341, 682, 341);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Random phases under a range of thresholds, extremes included
      wait_drained();
      write_threshold('0);
      random_phase(300);
      wait_drained();
      write_threshold('1);
      random_phase(250);
      wait_drained();
      write_threshold(THRESH_W'($urandom_range(1, 60)));
      random_phase(400);
      wait_drained();
      write_threshold(THRESH_W'($urandom_range(0, (1 << THRESH_W) - 1)));
      random_phase(250);
      wait_drained();
      write_threshold(THRESH_RESET);
      random_phase(450);

      // Drain and let any stray result show up
      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0)
         $display("tb_threshold_step_detector: PASS");
      else
         $display("tb_threshold_step_detector: FAIL");
      $finish;
   end

endmodule

[threshold_step_detector.f]
hw/rtl/tsd_pkg.sv
hw/rtl/tsd_sqsum.sv
hw/rtl/tsd_isqrt.sv
hw/rtl/tsd_cdiv.sv
hw/rtl/threshold_step_detector.sv
hw/rtl/tsd_checker.sv
bench/tb_threshold_step_detector.sv
